@@ design/segment_circle_hausdorff_distance_core_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef SEGMENT_CIRCLE_HAUSDORFF_DISTANCE_CORE_DEFINES_SVH
`define SEGMENT_CIRCLE_HAUSDORFF_DISTANCE_CORE_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define HDC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The expression must never be true out of reset.
`define HDC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ design/hdc_pkg.sv @@
package hdc_pkg;

    // Control word that travels down the pipeline next to each data word.
    typedef struct packed {
        logic valid;
    } pipe_tag_t;

endpackage

@@ design/hdc_sqrt.sv @@
module hdc_sqrt
    import hdc_pkg::*;
#(
    parameter int NW = 66
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_tag_t         in_tag,
    input  logic [NW-1:0]     in_value,
    output pipe_tag_t         out_tag,
    output logic [NW/2:0]     out_root
);

    localparam int QW = NW / 2;
    localparam int RW = QW + 2;

    logic [RW-1:0] rem_reg  [QW];
    logic [QW-1:0] root_reg [QW];
    logic [NW-1:0] num_reg  [QW];
    pipe_tag_t     tag_reg  [QW];

    logic [RW-1:0] rem_next  [QW];
    logic [QW-1:0] root_next [QW];
    logic [NW-1:0] num_next  [QW];

    logic [RW-1:0] rem_w  [QW+1];
    logic [QW-1:0] root_w [QW+1];
    logic [NW-1:0] num_w  [QW+1];
    pipe_tag_t     tag_w  [QW+1];

    pipe_tag_t     out_tag_reg;
    logic [QW:0]   out_root_reg;

    // Stage inputs: the ports feed the first stage, each register the next.
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign num_w[0]  = in_value;
    assign tag_w[0]  = in_tag;

    // One root bit per stage, restoring digit recurrence.
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        assign rem_sh       = {rem_w[s][QW-1:0], num_w[s][NW-1 -: 2]};
        assign trial        = {root_w[s], 2'b01};
        assign ge           = (rem_sh >= trial);
        assign rem_next[s]  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next[s] = {root_w[s][QW-2:0], ge};
        assign num_next[s]  = {num_w[s][NW-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else
            begin
                tag_reg[s] <= tag_w[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
            num_reg[s]  <= num_next[s];
        end

        assign rem_w[s+1]  = rem_reg[s];
        assign root_w[s+1] = root_reg[s];
        assign num_w[s+1]  = num_reg[s];
        assign tag_w[s+1]  = tag_reg[s];
    end

    // Round to nearest: a remainder above the floor root rounds up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else
        begin
            out_tag_reg <= tag_w[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rem_w[QW] > {2'b00, root_w[QW]})
        begin
            out_root_reg <= {1'b0, root_w[QW]} + {{QW{1'b0}}, 1'b1};
        end
        else
        begin
            out_root_reg <= {1'b0, root_w[QW]};
        end
    end

    assign out_tag  = out_tag_reg;
    assign out_root = out_root_reg;

endmodule

@@ design/hdc_div.sv @@
module hdc_div
    import hdc_pkg::*;
#(
    parameter int NW = 66,
    parameter int DW = 34,
    parameter int OW = 35
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pipe_tag_t     in_tag,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    output pipe_tag_t     out_tag,
    output logic [OW-1:0] out_quot
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] den_reg [NW];
    pipe_tag_t     tag_reg [NW];

    logic [DW-1:0] rem_next [NW];
    logic [NW-1:0] quo_next [NW];
    logic [NW-1:0] num_next [NW];

    logic [DW-1:0] rem_w [NW+1];
    logic [NW-1:0] quo_w [NW+1];
    logic [NW-1:0] num_w [NW+1];
    logic [DW-1:0] den_w [NW+1];
    pipe_tag_t     tag_w [NW+1];

    pipe_tag_t     out_tag_reg;
    logic [OW-1:0] out_quot_reg;
    logic [NW:0]   quot_up;
    logic [DW-1:0] den_left;

    assign rem_w[0] = '0;
    assign quo_w[0] = '0;
    assign num_w[0] = in_num;
    assign den_w[0] = in_den;
    assign tag_w[0] = in_tag;

    // One quotient bit per stage, restoring long division.
    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW:0] rem_sh;
        logic [DW:0] rem_sub;
        logic        ge;

        assign rem_sh      = {rem_w[s], num_w[s][NW-1]};
        assign rem_sub     = rem_sh - {1'b0, den_w[s]};
        assign ge          = (rem_sh >= {1'b0, den_w[s]});
        assign rem_next[s] = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        assign quo_next[s] = {quo_w[s][NW-2:0], ge};
        assign num_next[s] = {num_w[s][NW-2:0], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else
            begin
                tag_reg[s] <= tag_w[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
            num_reg[s] <= num_next[s];
            den_reg[s] <= den_w[s];
        end

        assign rem_w[s+1] = rem_reg[s];
        assign quo_w[s+1] = quo_reg[s];
        assign num_w[s+1] = num_reg[s];
        assign den_w[s+1] = den_reg[s];
        assign tag_w[s+1] = tag_reg[s];
    end

    // Round to nearest with ties up; a zero divisor gives zero.
    assign den_left = den_w[NW] - rem_w[NW];
    assign quot_up  = {1'b0, quo_w[NW]} + {{NW{1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else
        begin
            out_tag_reg <= tag_w[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (den_w[NW] == '0)
        begin
            out_quot_reg <= '0;
        end
        else if (rem_w[NW] >= den_left)
        begin
            out_quot_reg <= quot_up[OW-1:0];
        end
        else
        begin
            out_quot_reg <= quo_w[NW][OW-1:0];
        end
    end

    assign out_tag  = out_tag_reg;
    assign out_quot = out_quot_reg;

endmodule

@@ design/segment_circle_hausdorff_distance_core.sv @@
// Segment-circle distance pipeline. A new query word may be started in every
// clock cycle and busy never rises; each result word appears on
// hausdorff_dist for one cycle with done high. Each query passes through
// three front stages, then three parallel square-root pipelines of
// COORD_BITS+2 stages, then a long divider of 2*COORD_BITS+3 stages,
// and one output stage. The receiver cannot hold results off, so every
// done pulse must be captured.
module segment_circle_hausdorff_distance_core
    import hdc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic [COORD_BITS-2:0]     radius,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] finish_x,
    input  logic signed [COORD_BITS-1:0] finish_y,
    output logic                      done,
    output logic signed [COORD_BITS+2:0] hausdorff_dist
);

    localparam int C       = COORD_BITS;
    localparam int DFW     = C + 1;
    localparam int PW      = 2 * C + 2;
    localparam int SW      = 2 * C + 3;
    localparam int NW      = 2 * C + 2;
    localparam int LW      = C + 2;
    localparam int QOW     = C + 3;
    localparam int RW      = C - 1;
    localparam int EW      = C + 5;
    localparam int OW      = C + 3;
    localparam int SQ_LAT  = NW / 2 + 1;
    localparam int DIV_LAT = NW + 1;
    localparam int PIPE_LAT = 3 + SQ_LAT + DIV_LAT + 1;

    // Stage A: coordinate differences.
    logic                  va_reg;
    logic signed [DFW-1:0] sa_reg, sb_reg, cbx_reg, cby_reg, cex_reg, cey_reg;
    logic [RW-1:0]         ra_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg  <= DFW'(start_x) - DFW'(finish_x);
        sb_reg  <= DFW'(start_y) - DFW'(finish_y);
        cbx_reg <= DFW'(start_x) - DFW'(center_x);
        cby_reg <= DFW'(start_y) - DFW'(center_y);
        cex_reg <= DFW'(center_x) - DFW'(finish_x);
        cey_reg <= DFW'(center_y) - DFW'(finish_y);
        ra_reg  <= radius;
    end

    // Stage B: all products, one multiplier each.
    logic                 vb_reg;
    logic signed [PW-1:0] p_sacbx_reg, p_sbcby_reg, p_sacex_reg, p_sbcey_reg;
    logic signed [PW-1:0] p_sacby_reg, p_sbcbx_reg;
    logic signed [PW-1:0] q_cbx_reg, q_cby_reg, q_cex_reg, q_cey_reg, q_sa_reg, q_sb_reg;
    logic [RW-1:0]        rb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_sacbx_reg <= PW'(sa_reg) * PW'(cbx_reg);
        p_sbcby_reg <= PW'(sb_reg) * PW'(cby_reg);
        p_sacex_reg <= PW'(sa_reg) * PW'(cex_reg);
        p_sbcey_reg <= PW'(sb_reg) * PW'(cey_reg);
        p_sacby_reg <= PW'(sa_reg) * PW'(cby_reg);
        p_sbcbx_reg <= PW'(sb_reg) * PW'(cbx_reg);
        q_cbx_reg   <= PW'(cbx_reg) * PW'(cbx_reg);
        q_cby_reg   <= PW'(cby_reg) * PW'(cby_reg);
        q_cex_reg   <= PW'(cex_reg) * PW'(cex_reg);
        q_cey_reg   <= PW'(cey_reg) * PW'(cey_reg);
        q_sa_reg    <= PW'(sa_reg) * PW'(sa_reg);
        q_sb_reg    <= PW'(sb_reg) * PW'(sb_reg);
        rb_reg      <= ra_reg;
    end

    // Stage C: dot products, sums of squares, cross magnitude.
    logic signed [SW-1:0] dot1, dot2, cross_prod;
    logic [SW-1:0]        cross_abs;
    logic                 vc_reg;
    logic [NW-1:0]        nb_reg, ne_reg, ns_reg, cross_reg;
    logic [1:0]           flags_c_reg;
    logic [RW-1:0]        rc_reg;

    assign dot1       = SW'(p_sacbx_reg) + SW'(p_sbcby_reg);
    assign dot2       = SW'(p_sacex_reg) + SW'(p_sbcey_reg);
    assign cross_prod = SW'(p_sacby_reg) - SW'(p_sbcbx_reg);
    assign cross_abs  = cross_prod[SW-1] ? (~cross_prod + SW'(1)) : cross_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg         <= NW'(q_cbx_reg) + NW'(q_cby_reg);
        ne_reg         <= NW'(q_cex_reg) + NW'(q_cey_reg);
        ns_reg         <= NW'(q_sa_reg) + NW'(q_sb_reg);
        cross_reg      <= cross_abs[NW-1:0];
        // Bit 1: finish end selected; bit 0: start end selected.
        flags_c_reg[1] <= dot2[SW-1] || (dot2 == '0);
        flags_c_reg[0] <= dot1[SW-1] || (dot1 == '0);
        rc_reg         <= rb_reg;
    end

    // Three length pipelines in parallel.
    pipe_tag_t     tag_c;
    pipe_tag_t     tag_sq;
    logic [LW-1:0] lb_sq, le_sq, len_sq;

    assign tag_c.valid = vc_reg;

    hdc_sqrt #(.NW(NW)) u_sqrt_b
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (tag_c),
        .in_value (nb_reg),
        .out_tag  (tag_sq),
        .out_root (lb_sq)
    );

    hdc_sqrt #(.NW(NW)) u_sqrt_e
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (tag_c),
        .in_value (ne_reg),
        .out_tag  (),
        .out_root (le_sq)
    );

    hdc_sqrt #(.NW(NW)) u_sqrt_s
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (tag_c),
        .in_value (ns_reg),
        .out_tag  (),
        .out_root (len_sq)
    );

    // Side words that wait alongside the length pipelines.
    logic [NW-1:0] cross_dly_reg [SQ_LAT];
    logic [RW-1:0] r_sq_dly_reg  [SQ_LAT];
    logic [1:0]    f_sq_dly_reg  [SQ_LAT];

    always_ff @(posedge clk)
    begin
        cross_dly_reg[0] <= cross_reg;
        r_sq_dly_reg[0]  <= rc_reg;
        f_sq_dly_reg[0]  <= flags_c_reg;
        for (int i = 1; i < SQ_LAT; i++)
        begin
            cross_dly_reg[i] <= cross_dly_reg[i-1];
            r_sq_dly_reg[i]  <= r_sq_dly_reg[i-1];
            f_sq_dly_reg[i]  <= f_sq_dly_reg[i-1];
        end
    end

    // Perpendicular distance divider.
    pipe_tag_t      tag_dv;
    logic [QOW-1:0] quot_dv;

    hdc_div #(.NW(NW), .DW(LW), .OW(QOW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (tag_sq),
        .in_num   (cross_dly_reg[SQ_LAT-1]),
        .in_den   (len_sq),
        .out_tag  (tag_dv),
        .out_quot (quot_dv)
    );

    logic [LW-1:0] lb_dly_reg   [DIV_LAT];
    logic [LW-1:0] le_dly_reg   [DIV_LAT];
    logic [RW-1:0] r_dv_dly_reg [DIV_LAT];
    logic [1:0]    f_dv_dly_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        lb_dly_reg[0]   <= lb_sq;
        le_dly_reg[0]   <= le_sq;
        r_dv_dly_reg[0] <= r_sq_dly_reg[SQ_LAT-1];
        f_dv_dly_reg[0] <= f_sq_dly_reg[SQ_LAT-1];
        for (int i = 1; i < DIV_LAT; i++)
        begin
            lb_dly_reg[i]   <= lb_dly_reg[i-1];
            le_dly_reg[i]   <= le_dly_reg[i-1];
            r_dv_dly_reg[i] <= r_dv_dly_reg[i-1];
            f_dv_dly_reg[i] <= f_dv_dly_reg[i-1];
        end
    end

    // Final stage: pick the first term, take the largest, saturate.
    logic signed [EW-1:0] lb_e, le_e, r_e, q_e;
    logic signed [EW-1:0] term1, t_e, t_b, best_a, best;
    logic signed [EW-1:0] lim_hi, lim_lo;
    logic [1:0]           f_fin;
    logic                 done_reg;
    logic [OW-1:0]        dist_reg;

    assign lb_e   = EW'(lb_dly_reg[DIV_LAT-1]);
    assign le_e   = EW'(le_dly_reg[DIV_LAT-1]);
    assign r_e    = EW'(r_dv_dly_reg[DIV_LAT-1]);
    assign q_e    = EW'(quot_dv);
    assign f_fin  = f_dv_dly_reg[DIV_LAT-1];
    assign lim_hi = EW'({1'b0, {(OW-1){1'b1}}});
    assign lim_lo = -lim_hi - EW'(1);

    always_comb
    begin
        if (f_fin[1])
        begin
            term1 = le_e + r_e;
        end
        else if (f_fin[0])
        begin
            term1 = lb_e + r_e;
        end
        else
        begin
            term1 = q_e + r_e;
        end
        t_e    = le_e - r_e;
        t_b    = lb_e - r_e;
        best_a = (t_e > term1) ? t_e : term1;
        best   = (t_b > best_a) ? t_b : best_a;
        if (best > lim_hi)
        begin
            best = lim_hi;
        end
        if (best < lim_lo)
        begin
            best = lim_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag_dv.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= best[OW-1:0];
    end

    assign busy           = 1'b0;
    assign done           = done_reg;
    assign hausdorff_dist = dist_reg;

endmodule

@@ design/hdc_checker.sv @@
`include "segment_circle_hausdorff_distance_core_defines.svh"

module hdc_checker
    import hdc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int LAT = 105
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [COORD_BITS+2:0] hausdorff_dist
);

    // The pipeline never holds off a start.
    `HDC_ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy rose")

    // Every result word must have a matching earlier start.
    `HDC_ASSERT_IMPLIES(a_done_has_start, clk, rst_n, done, $past(start, LAT), "done without start")

    // The first term is a length plus the radius, so the largest term is never negative.
    `HDC_ASSERT_IMPLIES(a_nonneg, clk, rst_n, done, !hausdorff_dist[COORD_BITS+2], "negative result")

endmodule

bind segment_circle_hausdorff_distance_core hdc_checker
#(
    .COORD_BITS (COORD_BITS),
    .LAT        (PIPE_LAT)
)
u_hdc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .hausdorff_dist (hausdorff_dist)
);
